// File: hdl/assert_macros.svh
// Assertion helpers for the trie design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-next-cycle implication check.
`define CHECK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");

// Same-cycle implication check.
`define CHECK_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");

`endif

// File: hdl/lpmt_pkg.sv
// ----------------------------------------------------------------------------
// lpmt_pkg
// Shared types and codes for the binary trie prefix match block.
// ----------------------------------------------------------------------------
package lpmt_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_INVALID   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	localparam int MAX_LEN = 32;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK_RD,
		S_WALK_EV,
		S_INS_CHK,
		S_INS_POP,
		S_INS_LINK,
		S_MARK,
		S_RM_RD,
		S_RM_EV,
		S_RESULT
	} state_t;

	// Controller -> datapath commands
	typedef struct packed {
		logic clear_step;   // clear one node during init sweep
		logic load;         // capture request
		logic walk_rd;      // issue node read at cursor
		logic walk_adv;     // step down into child
		logic lkp_take;     // note value of current node
		logic pop_rd;       // read free stack top
		logic ins_link;     // link new node under cursor
		logic mark;         // set or clear the value of cursor node
		logic rm_rd;        // read node on way back up
		logic rm_free;      // unlink and free node
		logic rm_up;        // reload cursor node from path memory
		logic out_load;     // register result
	} cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic       clear_done;
		logic [1:0] op;
		logic       len_bad;
		logic       at_len;     // depth reached target (insert/remove)
		logic       at_leaf;    // depth reached address width (lookup)
		logic       child_none; // child of node read is zero
		logic       pool_short; // not enough free nodes
		logic       node_held;  // cursor node holds a value
		logic       rm_empty;   // node read on way up is empty
		logic       at_root;    // depth back at zero
	} stat_t;

endpackage

// File: hdl/ipv4_longest_prefix_match_trie.sv
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_match_trie
// Binary trie routing table: insert, remove and longest prefix lookup.
// ----------------------------------------------------------------------------
// channel | signals                                         | dir
// request | valid stall operation address prefix_length value_in | in
// result  | out_valid out_stall status value_out entry_count | out
// Lookup: reads one node per level, up to 33 levels, then registers the result;
//   a new request is taken only after that result has been loaded.
// Insert: walk, one pool check, pop and link per new node, then read and mark.
// Remove: full walk, mark, then free empty nodes climbing back to the root.
// Reset: a sweep over every node clears the node memory; stall stays high.
// A result waits in its output register while out_stall is high; stall holds.
module ipv4_longest_prefix_match_trie import lpmt_pkg::*; #(
	parameter int NODES = 1024,
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic [1:0]  operation,
	input  logic [31:0] address,
	input  logic [5:0]  prefix_length,
	input  logic [31:0] value_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] value_out,
	output logic [10:0] entry_count
);
`include "assert_macros.svh"

	cmd_t       cmd;
	stat_t      stat;
	logic       found;
	logic       res_set;
	logic [1:0] res_status;

	lpmt_ctrl u_ctrl (
		.clk, .arst_n, .stat, .found, .cmd,
		.in_valid(valid), .in_stall(stall),
		.out_valid, .out_stall, .res_set, .res_status
	);

	lpmt_datapath #(.NODES(NODES), .VALUE_BITS(VALUE_BITS)) u_dp (
		.clk, .arst_n, .cmd, .stat, .found,
		.in_op(operation), .in_addr(address), .in_len(prefix_length),
		.in_value(value_in), .res_status,
		.out_status(status), .out_value(value_out), .out_count(entry_count)
	);

	`CHECK_NEXT(a_res_valid, clk, arst_n, res_set, out_valid)
	`CHECK_NOW(a_no_take_busy, clk, arst_n, out_valid && out_stall, !res_set)
	`CHECK_NOW(a_one_cmd, clk, arst_n, 1'b1, $onehot0({cmd.ins_link, cmd.rm_free, cmd.clear_step}))

endmodule

// File: hdl/lpmt_datapath.sv
// ----------------------------------------------------------------------------
// lpmt_datapath
// Node memories, free stack, path memory and walk registers.
// ----------------------------------------------------------------------------
module lpmt_datapath import lpmt_pkg::*; #(
	parameter int NODES = 1024,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	output logic                  found,
	input  logic [1:0]            in_op,
	input  logic [31:0]           in_addr,
	input  logic [5:0]            in_len,
	input  logic [31:0]           in_value,
	input  logic [1:0]            res_status,
	output logic [1:0]            out_status,
	output logic [31:0]           out_value,
	output logic [10:0]           out_count
);
	localparam int NW = $clog2(NODES);
	localparam int CW = $clog2(NODES + 1);

	logic [NW-1:0]         left_mem [NODES];
	logic [NW-1:0]         right_mem [NODES];
	logic                  held_mem [NODES];
	logic [VALUE_BITS-1:0] val_mem [NODES];
	logic [NW-1:0]         free_mem [NODES];
	logic [NW-1:0]         path_mem [MAX_LEN+1];

	logic [NW-1:0] clr_q;
	logic          clr_done_q;
	logic [1:0]    op_q;
	logic [31:0]   addr_q;
	logic [5:0]    len_q;
	logic [VALUE_BITS-1:0] vin_q;
	logic [5:0]    depth_q;
	logic [NW-1:0] node_q;
	logic [CW-1:0] free_q;
	logic [10:0]   pfx_q;
	logic [NW-1:0] rd_l_q, rd_r_q, pop_q, path_rd_q;
	logic          rd_h_q;
	logic [VALUE_BITS-1:0] rd_v_q;
	logic          found_q;
	logic [VALUE_BITS-1:0] best_q;

	logic          dir_bit, up_bit;
	logic [NW-1:0] child;
	logic [CW-1:0] need;

	assign dir_bit = addr_q[5'd31 - depth_q[4:0]];
	assign up_bit  = addr_q[5'd31 - 5'(depth_q - 6'd1)];
	assign child   = dir_bit ? rd_r_q : rd_l_q;
	assign need    = CW'(len_q - depth_q);

	assign stat.clear_done = clr_done_q;
	assign stat.op         = op_q;
	assign stat.len_bad    = len_q > 6'(MAX_LEN);
	assign stat.at_len     = depth_q == len_q;
	assign stat.at_leaf    = depth_q == 6'(MAX_LEN);
	assign stat.child_none = child == '0;
	assign stat.pool_short = need > free_q;
	assign stat.node_held  = rd_h_q;
	assign stat.rm_empty   = !rd_h_q && rd_l_q == '0 && rd_r_q == '0;
	assign stat.at_root    = depth_q == 6'd0;

	assign found = found_q;

	// memories: registered reads; a link writes the new node and its parent together
	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			left_mem[clr_q]  <= '0;
			right_mem[clr_q] <= '0;
			held_mem[clr_q]  <= 1'b0;
			free_mem[clr_q]  <= NW'(clr_q + NW'(1));
		end else if (cmd.ins_link) begin
			left_mem[pop_q]  <= '0;
			right_mem[pop_q] <= '0;
			held_mem[pop_q]  <= 1'b0;
			if (dir_bit) right_mem[node_q] <= pop_q;
			else left_mem[node_q] <= pop_q;
		end else if (cmd.rm_free) begin
			if (up_bit) right_mem[path_rd_q] <= '0;
			else left_mem[path_rd_q] <= '0;
			free_mem[free_q[NW-1:0]] <= node_q;
		end
		if (cmd.mark) begin
			held_mem[node_q] <= op_q == OP_INSERT;
			if (op_q == OP_INSERT) val_mem[node_q] <= vin_q;
		end
		if (cmd.walk_adv) path_mem[depth_q + 6'd1] <= child;
		if (cmd.load) path_mem[0] <= '0;
		if (cmd.walk_rd || cmd.rm_rd) begin
			rd_l_q <= left_mem[node_q];
			rd_r_q <= right_mem[node_q];
			rd_h_q <= held_mem[node_q];
			rd_v_q <= val_mem[node_q];
		end
		if (cmd.pop_rd) pop_q <= free_mem[NW'(free_q - CW'(1))];
		if (cmd.rm_rd) path_rd_q <= path_mem[depth_q - 6'd1];
		if (cmd.load) begin
			op_q   <= in_op;
			addr_q <= in_addr;
			len_q  <= in_len;
			vin_q  <= VALUE_BITS'(in_value);
		end
		if (cmd.lkp_take && rd_h_q) best_q <= rd_v_q;
		if (cmd.out_load) begin
			out_status <= res_status;
			out_value  <= (res_status == ST_OK && op_q == OP_LOOKUP) ? 32'(best_q) : 32'd0;
			out_count  <= pfx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_done_q <= 1'b0;
			depth_q    <= '0;
			node_q     <= '0;
			free_q     <= CW'(NODES - 1);
			pfx_q      <= '0;
			found_q    <= 1'b0;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= NW'(clr_q + NW'(1));
				if (clr_q == NW'(NODES - 1)) clr_done_q <= 1'b1;
			end
			if (cmd.load) begin
				depth_q <= '0;
				node_q  <= '0;
				found_q <= 1'b0;
			end
			if (cmd.walk_adv) begin
				depth_q <= depth_q + 6'd1;
				node_q  <= child;
			end
			if (cmd.lkp_take && rd_h_q) found_q <= 1'b1;
			if (cmd.ins_link) begin
				free_q  <= free_q - CW'(1);
				depth_q <= depth_q + 6'd1;
				node_q  <= pop_q;
			end
			if (cmd.mark) begin
				if (op_q == OP_INSERT && !rd_h_q) pfx_q <= pfx_q + 11'd1;
				if (op_q == OP_REMOVE) pfx_q <= pfx_q - 11'd1;
			end
			if (cmd.rm_free) begin
				free_q  <= free_q + CW'(1);
				depth_q <= depth_q - 6'd1;
				node_q  <= path_rd_q;
			end
			if (cmd.rm_up) node_q <= path_mem[depth_q];
		end
	end

endmodule

// File: hdl/lpmt_ctrl.sv
// ----------------------------------------------------------------------------
// lpmt_ctrl
// Sequencer for init sweep, trie walk, insert, remove and result hand-off.
// ----------------------------------------------------------------------------
module lpmt_ctrl import lpmt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  stat_t      stat,
	input  logic       found,
	output cmd_t       cmd,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       res_set,
	output logic [1:0] res_status
);
	state_t state_q, state_d;
	logic   ov_q;
	logic [1:0] rs_q, rs_d;

	assign out_valid  = ov_q;
	assign res_status = rs_q;
	assign res_set    = cmd.out_load;
	assign in_stall   = !(state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ov_q    <= 1'b0;
			rs_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			rs_q    <= rs_d;
			if (cmd.out_load) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		rs_d    = rs_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.clear_done) state_d = S_IDLE;
				else cmd.clear_step = 1'b1;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_WALK_RD;
				end
			end
			S_WALK_RD: begin
				if ((stat.op == OP_INSERT || stat.op == OP_REMOVE) && stat.len_bad) begin
					rs_d    = ST_INVALID;
					state_d = S_RESULT;
				end else if (stat.op != OP_INSERT && stat.op != OP_REMOVE &&
						stat.op != OP_LOOKUP) begin
					rs_d    = ST_INVALID;
					state_d = S_RESULT;
				end else begin
					cmd.walk_rd = 1'b1;
					state_d     = S_WALK_EV;
				end
			end
			S_WALK_EV: begin
				if (stat.op == OP_LOOKUP) begin
					cmd.lkp_take = 1'b1;
					if (stat.at_leaf || stat.child_none) begin
						rs_d    = (found || stat.node_held) ? ST_OK : ST_NOT_FOUND;
						state_d = S_RESULT;
					end else begin
						cmd.walk_adv = 1'b1;
						state_d      = S_WALK_RD;
					end
				end else if (stat.at_len) begin
					if (stat.op == OP_INSERT) begin
						cmd.mark = 1'b1;
						rs_d     = ST_OK;
						state_d  = S_RESULT;
					end else if (stat.node_held) begin
						cmd.mark = 1'b1;
						rs_d     = ST_OK;
						state_d  = stat.at_root ? S_RESULT : S_RM_RD;
					end else begin
						rs_d    = ST_NOT_FOUND;
						state_d = S_RESULT;
					end
				end else if (stat.child_none) begin
					if (stat.op == OP_INSERT) state_d = S_INS_CHK;
					else begin
						rs_d    = ST_NOT_FOUND;
						state_d = S_RESULT;
					end
				end else begin
					cmd.walk_adv = 1'b1;
					state_d      = S_WALK_RD;
				end
			end
			S_INS_CHK: begin
				if (stat.pool_short) begin
					rs_d    = ST_FULL;
					state_d = S_RESULT;
				end else state_d = S_INS_POP;
			end
			S_INS_POP: begin
				if (stat.at_len) begin
					cmd.walk_rd = 1'b1;
					state_d     = S_MARK;
				end else begin
					cmd.pop_rd = 1'b1;
					state_d    = S_INS_LINK;
				end
			end
			S_INS_LINK: begin
				cmd.ins_link = 1'b1;
				state_d      = S_INS_POP;
			end
			S_MARK: begin
				cmd.mark = 1'b1;
				rs_d     = ST_OK;
				state_d  = S_RESULT;
			end
			S_RM_RD: begin
				// stop at the root, which is never freed
				if (stat.at_root) state_d = S_RESULT;
				else begin
					cmd.rm_rd = 1'b1;
					state_d   = S_RM_EV;
				end
			end
			S_RM_EV: begin
				// free the node and climb while it stays empty
				if (stat.rm_empty) begin
					cmd.rm_free = 1'b1;
					state_d     = S_RM_RD;
				end else state_d = S_RESULT;
			end
			S_RESULT: begin
				if (!out_valid || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
